// ===== sv/crmc_pkg.sv =====
// ----------------------------------------------------------------------------
// crmc_pkg
// Shared types, constants and helpers of the colour range mask closing unit.
// ----------------------------------------------------------------------------
package crmc_pkg;

    localparam int RADIUS    = 5;
    localparam int WIN       = 2 * RADIUS + 1;
    localparam int HIST_W    = 2 * RADIUS;
    localparam int MAX_WIDTH = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int DIM_W     = 11;
    localparam int ROW_W     = 11;
    localparam int EXP_W     = COL_W + 2;
    localparam int STEP_W    = 21;
    localparam int CH_W      = 8;
    localparam int IDX_W     = 4;

    localparam logic [IDX_W-1:0] REG_LOW_CH0  = 4'd0;
    localparam logic [IDX_W-1:0] REG_LOW_CH1  = 4'd1;
    localparam logic [IDX_W-1:0] REG_LOW_CH2  = 4'd2;
    localparam logic [IDX_W-1:0] REG_HIGH_CH0 = 4'd3;
    localparam logic [IDX_W-1:0] REG_HIGH_CH1 = 4'd4;
    localparam logic [IDX_W-1:0] REG_HIGH_CH2 = 4'd5;
    localparam logic [IDX_W-1:0] REG_WIDTH    = 4'd6;
    localparam logic [IDX_W-1:0] REG_HEIGHT   = 4'd7;

    localparam logic [DIM_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [DIM_W-1:0] HEIGHT_RESET = 11'd480;

    typedef struct packed {
        logic            action;
        logic [CH_W-1:0] chan0;
        logic [CH_W-1:0] chan1;
        logic [CH_W-1:0] chan2;
    } pixel_t;

    typedef struct packed {
        logic             mask_bit;
        logic [COL_W-1:0] out_col;
        logic [9:0]       out_row;
        logic             frame_last;
    } result_t;

    typedef struct packed {
        logic             valid;
        logic             val;
        logic [COL_W-1:0] tag;
    } cell_t;

    typedef struct packed {
        logic             en;
        logic             clr;
        logic             use_and;
        logic [COL_W-1:0] col;
        logic [COL_W-1:0] col_next;
        logic [ROW_W-1:0] row;
        logic [DIM_W-1:0] height;
        logic [COL_W-1:0] center;
    } stage_ctl_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] mx);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = DIM_W'(1);
        else if (v > mx)
            r = mx;
        else
            r = v;
        return r;
    endfunction

    function automatic logic [STEP_W-1:0] delay_of(input logic [DIM_W-1:0] w);
        return STEP_W'(RADIUS) * (STEP_W'(w) + STEP_W'(1));
    endfunction

endpackage

// ===== sv/crmc_cell.sv =====
// ----------------------------------------------------------------------------
// crmc_cell
// One cell of the horizontal window chain: holds one column value and its tag.
// ----------------------------------------------------------------------------
module crmc_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        clr,
    input  logic                        use_and,
    input  crmc_pkg::cell_t             d,
    input  logic [crmc_pkg::EXP_W-1:0]  exp_col,
    output crmc_pkg::cell_t             q,
    output logic                        term
);

    logic                          valid_reg;
    logic                          val_reg;
    logic [crmc_pkg::COL_W-1:0]    tag_reg;
    logic                          hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= clr ? 1'b0 : d.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            val_reg <= d.val;
            tag_reg <= d.tag;
        end
    end

    assign q   = '{valid: valid_reg, val: val_reg, tag: tag_reg};
    assign hit = valid_reg && ({2'b00, tag_reg} == exp_col);
    assign term = use_and ? (!hit || val_reg) : (hit && val_reg);

endmodule

// ===== sv/crmc_stage.sv =====
// ----------------------------------------------------------------------------
// crmc_stage
// One square morphology stage: column history store, vertical reduce and a
// chain of cells for the horizontal reduce. OR for dilation, AND for erosion.
// ----------------------------------------------------------------------------
module crmc_stage (
    input  logic                  clk,
    input  logic                  rst_n,
    input  crmc_pkg::stage_ctl_t  ctl,
    input  logic                  bit_in,
    output logic                  result
);

    localparam int R = crmc_pkg::RADIUS;
    localparam int N = crmc_pkg::HIST_W;

    logic [N-1:0]                  hist_mem [crmc_pkg::MAX_WIDTH];
    logic [N-1:0]                  hist_q_reg;
    logic [N-1:0]                  hist_wr;
    logic [crmc_pkg::COL_W-1:0]    rd_addr;
    logic [N:0]                    vterm;
    logic                          vbit;
    logic [N:0]                    hterm;
    crmc_pkg::cell_t               chain [N+1];
    logic [crmc_pkg::EXP_W-1:0]    exp_col [N+1];
    logic                          new_hit;

    assign hist_wr = {hist_q_reg[N-2:0], bit_in};
    assign rd_addr = ctl.en ? ctl.col_next : ctl.col;

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            hist_mem[ctl.col] <= hist_wr;
        end
        if (ctl.en && (ctl.col_next == ctl.col))
        begin
            hist_q_reg <= hist_wr;
        end
        else
        begin
            hist_q_reg <= hist_mem[rd_addr];
        end
    end

    always_comb
    begin
        logic rv;
        logic b;
        for (int k = 0; k <= N; k++)
        begin
            rv = (ctl.row >= crmc_pkg::ROW_W'(k)) &&
                 ((ctl.row - crmc_pkg::ROW_W'(k)) < ctl.height);
            b  = (k == 0) ? bit_in : hist_q_reg[(k == 0) ? 0 : k - 1];
            vterm[k] = ctl.use_and ? (!rv || b) : (rv && b);
        end
    end

    assign vbit = ctl.use_and ? (&vterm) : (|vterm);

    always_comb
    begin
        for (int j = 0; j <= N; j++)
        begin
            exp_col[j] = {2'b00, ctl.center} + crmc_pkg::EXP_W'(R) - crmc_pkg::EXP_W'(j);
        end
    end

    assign chain[0] = '{valid: 1'b1, val: vbit, tag: ctl.col};
    assign new_hit  = ({2'b00, ctl.col} == exp_col[0]);
    assign hterm[0] = ctl.use_and ? (!new_hit || vbit) : (new_hit && vbit);

    for (genvar j = 1; j <= N; j++)
    begin : g_cell
        crmc_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (ctl.en),
            .clr     (ctl.clr),
            .use_and (ctl.use_and),
            .d       (chain[j-1]),
            .exp_col (exp_col[j]),
            .q       (chain[j]),
            .term    (hterm[j])
        );
    end

    assign result = ctl.use_and ? (&hterm) : (|hterm);

endmodule

// ===== sv/color_range_mask_closing_unit.sv =====
// ----------------------------------------------------------------------------
// color_range_mask_closing_unit
// Colour box threshold followed by an 11x11 closing (dilate, then erode).
// Output: the result for a pixel leaves on the beat of step t + 2*5*(W+1),
//   registered in the cycle after that beat is accepted.
// Throughput: one beat per cycle unless a waiting result stalls on mask_ready;
//   the column history stores take one read and one write per cycle.
// Reset: registers return to their defaults, counters and cell valids clear.
// ----------------------------------------------------------------------------
module color_range_mask_closing_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [crmc_pkg::IDX_W-1:0]      cfg_index,
    input  logic [crmc_pkg::DIM_W-1:0]      cfg_data,
    input  logic                            pixel_valid,
    output logic                            pixel_ready,
    input  crmc_pkg::pixel_t                pixel,
    output logic                            mask_valid,
    input  logic                            mask_ready,
    output crmc_pkg::result_t               mask
);

    localparam logic [crmc_pkg::DIM_W-1:0] MAXW = crmc_pkg::DIM_W'(crmc_pkg::MAX_WIDTH);
    localparam logic [crmc_pkg::DIM_W-1:0] MAXH = crmc_pkg::DIM_W'(crmc_pkg::MAX_HEIGHT);

    logic [crmc_pkg::CH_W-1:0]   low0_reg, low1_reg, low2_reg;
    logic [crmc_pkg::CH_W-1:0]   high0_reg, high1_reg, high2_reg;
    logic [crmc_pkg::DIM_W-1:0]  wcfg_reg, hcfg_reg;
    logic [crmc_pkg::DIM_W-1:0]  w_reg, h_reg;
    logic [crmc_pkg::STEP_W-1:0] dd_reg, dd2_reg, step_reg;
    logic [crmc_pkg::COL_W-1:0]  vcol_reg, dcol_reg, ecol_reg;
    logic [crmc_pkg::ROW_W-1:0]  vrow_reg, drow_reg;
    logic [crmc_pkg::COL_W-1:0]  erow_reg;
    logic                        out_valid_reg;
    crmc_pkg::result_t           out_reg;

    logic                        is_pixel, first, raw_active, ignore, step;
    logic                        dil_active, emit_active, last, in_box, raw_bit;
    logic [crmc_pkg::DIM_W-1:0]  w_use, w_new, h_new;
    logic [crmc_pkg::COL_W-1:0]  vcol_next, dcol_next, ecol_next;
    logic [crmc_pkg::ROW_W-1:0]  vrow_next, drow_next;
    logic [crmc_pkg::COL_W-1:0]  erow_next;
    logic [crmc_pkg::STEP_W-1:0] step_next;
    crmc_pkg::stage_ctl_t        dil_ctl, ero_ctl;
    logic                        dil_bit, ero_bit;

    assign cfg_ready   = 1'b1;
    assign pixel_ready = !out_valid_reg || mask_ready;
    assign mask_valid  = out_valid_reg;
    assign mask        = out_reg;

    assign is_pixel    = !pixel.action;
    assign first       = (step_reg == '0) && is_pixel;
    assign w_new       = crmc_pkg::clamp_dim(wcfg_reg, MAXW);
    assign h_new       = crmc_pkg::clamp_dim(hcfg_reg, MAXH);
    assign w_use       = first ? w_new : w_reg;
    assign raw_active  = vrow_reg < h_reg;
    assign ignore      = !is_pixel && raw_active;
    assign step        = pixel_valid && pixel_ready && !ignore;
    assign dil_active  = step_reg >= dd_reg;
    assign emit_active = step_reg >= dd2_reg;
    assign last        = ({1'b0, erow_reg} == (h_reg - 11'd1)) &&
                         ({1'b0, ecol_reg} == (w_reg - 11'd1));
    assign in_box      = (pixel.chan0 >= low0_reg) && (pixel.chan1 >= low1_reg) &&
                         (pixel.chan2 >= low2_reg) && (pixel.chan0 <= high0_reg) &&
                         (pixel.chan1 <= high1_reg) && (pixel.chan2 <= high2_reg);
    assign raw_bit     = in_box && is_pixel && raw_active;

    always_comb
    begin
        step_next = step_reg + crmc_pkg::STEP_W'(1);
        vcol_next = vcol_reg;
        vrow_next = vrow_reg;
        dcol_next = dcol_reg;
        drow_next = drow_reg;
        ecol_next = ecol_reg;
        erow_next = erow_reg;
        if (({1'b0, vcol_reg} + 11'd1) >= w_use)
        begin
            vcol_next = '0;
            vrow_next = vrow_reg + crmc_pkg::ROW_W'(1);
        end
        else
        begin
            vcol_next = vcol_reg + crmc_pkg::COL_W'(1);
        end
        if (dil_active)
        begin
            if (({1'b0, dcol_reg} + 11'd1) >= w_reg)
            begin
                dcol_next = '0;
                drow_next = drow_reg + crmc_pkg::ROW_W'(1);
            end
            else
            begin
                dcol_next = dcol_reg + crmc_pkg::COL_W'(1);
            end
        end
        if (emit_active)
        begin
            if (({1'b0, ecol_reg} + 11'd1) >= w_reg)
            begin
                ecol_next = '0;
                erow_next = erow_reg + crmc_pkg::COL_W'(1);
            end
            else
            begin
                ecol_next = ecol_reg + crmc_pkg::COL_W'(1);
            end
        end
        if (emit_active && last)
        begin
            step_next = '0;
            vcol_next = '0;
            vrow_next = '0;
            dcol_next = '0;
            drow_next = '0;
            ecol_next = '0;
            erow_next = '0;
        end
    end

    always_comb
    begin
        dil_ctl.en       = step;
        dil_ctl.clr      = emit_active && last;
        dil_ctl.use_and  = 1'b0;
        dil_ctl.col      = vcol_reg;
        dil_ctl.col_next = vcol_next;
        dil_ctl.row      = vrow_reg;
        dil_ctl.height   = h_reg;
        dil_ctl.center   = dcol_reg;
        ero_ctl.en       = step && dil_active;
        ero_ctl.clr      = emit_active && last;
        ero_ctl.use_and  = 1'b1;
        ero_ctl.col      = dcol_reg;
        ero_ctl.col_next = dcol_next;
        ero_ctl.row      = drow_reg;
        ero_ctl.height   = h_reg;
        ero_ctl.center   = ecol_reg;
    end

    crmc_stage u_dilate (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (dil_ctl),
        .bit_in (raw_bit),
        .result (dil_bit)
    );

    crmc_stage u_erode (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ero_ctl),
        .bit_in (dil_bit),
        .result (ero_bit)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low0_reg  <= '0;
            low1_reg  <= '0;
            low2_reg  <= '0;
            high0_reg <= '1;
            high1_reg <= '1;
            high2_reg <= '1;
            wcfg_reg  <= crmc_pkg::WIDTH_RESET;
            hcfg_reg  <= crmc_pkg::HEIGHT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                crmc_pkg::REG_LOW_CH0:  low0_reg  <= cfg_data[crmc_pkg::CH_W-1:0];
                crmc_pkg::REG_LOW_CH1:  low1_reg  <= cfg_data[crmc_pkg::CH_W-1:0];
                crmc_pkg::REG_LOW_CH2:  low2_reg  <= cfg_data[crmc_pkg::CH_W-1:0];
                crmc_pkg::REG_HIGH_CH0: high0_reg <= cfg_data[crmc_pkg::CH_W-1:0];
                crmc_pkg::REG_HIGH_CH1: high1_reg <= cfg_data[crmc_pkg::CH_W-1:0];
                crmc_pkg::REG_HIGH_CH2: high2_reg <= cfg_data[crmc_pkg::CH_W-1:0];
                crmc_pkg::REG_WIDTH:    wcfg_reg  <= cfg_data;
                crmc_pkg::REG_HEIGHT:   hcfg_reg  <= cfg_data;
                default:                ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg    <= crmc_pkg::WIDTH_RESET;
            h_reg    <= crmc_pkg::HEIGHT_RESET;
            dd_reg   <= crmc_pkg::delay_of(crmc_pkg::WIDTH_RESET);
            dd2_reg  <= crmc_pkg::delay_of(crmc_pkg::WIDTH_RESET) << 1;
            step_reg <= '0;
            vcol_reg <= '0;
            vrow_reg <= '0;
            dcol_reg <= '0;
            drow_reg <= '0;
            ecol_reg <= '0;
            erow_reg <= '0;
        end
        else if (step)
        begin
            if (first)
            begin
                w_reg   <= w_new;
                h_reg   <= h_new;
                dd_reg  <= crmc_pkg::delay_of(w_new);
                dd2_reg <= crmc_pkg::delay_of(w_new) << 1;
            end
            step_reg <= step_next;
            vcol_reg <= vcol_next;
            vrow_reg <= vrow_next;
            dcol_reg <= dcol_next;
            drow_reg <= drow_next;
            ecol_reg <= ecol_next;
            erow_reg <= erow_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step && emit_active)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (mask_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && emit_active)
        begin
            out_reg <= '{mask_bit:   ero_bit,
                         out_col:    ecol_reg,
                         out_row:    erow_reg,
                         frame_last: last};
        end
    end

endmodule

// ===== sv/crmc_checker.sv =====
// ----------------------------------------------------------------------------
// crmc_checker
// Port-level checks of the closing unit, bound to the top level.
// ----------------------------------------------------------------------------
module crmc_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_ready,
    input  logic               pixel_valid,
    input  logic               pixel_ready,
    input  logic               mask_valid,
    input  logic               mask_ready,
    input  crmc_pkg::result_t  mask
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        mask_valid && !mask_ready |=> mask_valid && $stable(mask))
        else $error("result beat dropped or changed while stalled");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !pixel_ready |-> mask_valid && !mask_ready)
        else $error("input stalled without a waiting result");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(mask_valid) |-> $past(pixel_valid && pixel_ready))
        else $error("result raised without an input beat");

    a_cfg_open: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration port blocked");

endmodule

bind color_range_mask_closing_unit crmc_checker u_crmc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_ready   (cfg_ready),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .mask_valid  (mask_valid),
    .mask_ready  (mask_ready),
    .mask        (mask)
);
